FILE: rtl/ffr_pkg.sv
// Shared types, codes and default sizes for the frame flip and rotate engine.
package ffr_pkg;

	localparam int DEF_MAX_SIDE   = 256;
	localparam int DEF_PIXEL_BITS = 16;
	localparam int QUEUE_DEPTH    = 4;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 9;

	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ORIENT_MODE  = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [2:0] {
		MODE_PASS     = 3'd0,
		MODE_MIRROR_H = 3'd1,
		MODE_MIRROR_V = 3'd2,
		MODE_ROT90    = 3'd3,
		MODE_ROT180   = 3'd4,
		MODE_ROT270   = 3'd5
	} orient_mode_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_ERROR = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic        op;
		logic [15:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic [15:0] pixel_out;
		logic        last_pixel;
		logic        status;
	} result_t;

endpackage

FILE: rtl/frame_flip_rotate_engine.sv
// Top level of the frame flip and rotate engine.
//
// The engine loads one grayscale frame of frame_width by frame_height pixels
// as write requests in raster order, then answers read requests with the
// frame mirrored or rotated by orient_mode, in output raster order. A request
// is taken at a rising edge where start is high and busy is low. Writes give
// no result; every read gives exactly one result, shown on result for one
// cycle with done high. The receiver cannot stall the engine, so results
// must be taken the cycle they appear. The engine takes one request per
// clock: the front end decides each request and forms its store address in
// the cycle it is taken, and the back end performs one access per clock on
// a single-port frame store, so the short queue between them does not fill
// and busy stays low. A request taken at a rising edge is written into the
// queue, the back end pops it and reads the store into the registered
// result stage, and that stage drives result and done. A read before the
// frame is complete returns status 1 and pixel 0. After the last output
// pixel is read the engine rearms for a new frame. Configuration is written
// through cfg_we, cfg_idx and cfg_wdata while no request is in flight; it
// takes effect for the next request.

module frame_flip_rotate_engine import ffr_pkg::*; #(
	parameter int MAX_SIDE   = DEF_MAX_SIDE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  req_t                     req,
	output logic                     done,
	output result_t                  result,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	// Command word: kind, last flag, store address and pixel data.
	localparam int CMD_BITS = 2 + 1 + $clog2(MAX_SIDE * MAX_SIDE) + PIXEL_BITS;

	logic                accept;
	logic                push;
	logic [CMD_BITS-1:0] push_cmd;
	logic [CMD_BITS-1:0] head_cmd;
	logic                q_empty, q_full;
	logic                pop;

	// A request is taken whenever the queue has room.
	assign busy   = q_full;
	assign accept = start && !busy;

	// The back end never stalls, so it drains one command every cycle while the queue is not empty.
	assign pop = !q_empty;

	ffr_front #(
		.MAX_SIDE   (MAX_SIDE),
		.PIXEL_BITS (PIXEL_BITS),
		.CMD_BITS   (CMD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.req       (req),
		.push      (push),
		.cmd       (push_cmd)
	);

	ffr_queue #(
		.WIDTH (CMD_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.head      (head_cmd),
		.empty     (q_empty),
		.full      (q_full)
	);

	ffr_back #(
		.MAX_SIDE   (MAX_SIDE),
		.PIXEL_BITS (PIXEL_BITS),
		.CMD_BITS   (CMD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop),
		.cmd       (head_cmd),
		.done      (done),
		.result    (result)
	);

endmodule

FILE: rtl/ffr_front.sv
// Front end: configuration registers, write and read counters, address generation.
module ffr_front import ffr_pkg::*; #(
	parameter int MAX_SIDE   = DEF_MAX_SIDE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int CMD_BITS   = 2 + 1 + $clog2(MAX_SIDE * MAX_SIDE) + PIXEL_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                     accept,
	input  req_t                     req,
	output logic                     push,
	output logic [CMD_BITS-1:0]      cmd
);

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = $clog2(MAX_SIDE);
	localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  last;
		logic [AW-1:0]         addr;
		logic [PIXEL_BITS-1:0] data;
	} cmd_t;

	logic [CFG_DATA_BITS-1:0] width_q, height_q;
	logic [2:0]               mode_q;
	logic [SW-1:0]            write_row_q;
	logic [CW-1:0]            write_col_q;
	logic [CW-1:0]            read_row_q, read_col_q;
	logic                     loaded_q;

	logic [SW-1:0] w_eff, h_eff, ow, oh;
	logic [SW-1:0] col_inc, row_inc, rc_inc, rr_inc;
	logic [CW-1:0] r, c, sr, sc;
	logic          last;
	logic          swap;
	cmd_t          cmd_c;

	function automatic logic [SW-1:0] side_of(input logic [CFG_DATA_BITS-1:0] v);
		logic [31:0] v32;
		v32 = 32'(v);
		if (v32 == 32'd0)
			return SW'(1);
		else if (v32 > 32'(MAX_SIDE))
			return SW'(MAX_SIDE);
		else
			return SW'(v32);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DATA_BITS'(256);
			height_q <= CFG_DATA_BITS'(256);
			mode_q   <= MODE_PASS;
		end else if (cfg_we) begin
			if (cfg_idx == REG_FRAME_WIDTH)
				width_q <= cfg_wdata;
			else if (cfg_idx == REG_FRAME_HEIGHT)
				height_q <= cfg_wdata;
			else if (cfg_idx == REG_ORIENT_MODE)
				mode_q <= cfg_wdata[2:0];
		end
	end

	always_comb begin
		w_eff = side_of(width_q);
		h_eff = side_of(height_q);
		swap  = (mode_q == MODE_ROT90) || (mode_q == MODE_ROT270);
		ow    = swap ? h_eff : w_eff;
		oh    = swap ? w_eff : h_eff;

		// Read position saturates when the output frame has shrunk.
		r = (SW'(read_row_q) < oh) ? read_row_q : CW'(oh - SW'(1));
		c = (SW'(read_col_q) < ow) ? read_col_q : CW'(ow - SW'(1));

		case (orient_mode_t'(mode_q))
			MODE_MIRROR_H: begin
				sr = r;
				sc = CW'(w_eff - SW'(1) - SW'(c));
			end
			MODE_MIRROR_V: begin
				sr = CW'(h_eff - SW'(1) - SW'(r));
				sc = c;
			end
			MODE_ROT90: begin
				sr = CW'(h_eff - SW'(1) - SW'(c));
				sc = r;
			end
			MODE_ROT180: begin
				sr = CW'(h_eff - SW'(1) - SW'(r));
				sc = CW'(w_eff - SW'(1) - SW'(c));
			end
			MODE_ROT270: begin
				sr = c;
				sc = CW'(w_eff - SW'(1) - SW'(r));
			end
			default: begin
				sr = r;
				sc = c;
			end
		endcase

		last    = (SW'(r) == oh - SW'(1)) && (SW'(c) == ow - SW'(1));
		rc_inc  = SW'(c) + SW'(1);
		rr_inc  = SW'(r) + SW'(1);
		col_inc = SW'(write_col_q) + SW'(1);
		row_inc = write_row_q + SW'(1);

		push       = 1'b0;
		cmd_c.kind = CMD_WRITE;
		cmd_c.last = 1'b0;
		cmd_c.addr = AW'(write_row_q[CW-1:0]) * AW'(MAX_SIDE) + AW'(write_col_q);
		cmd_c.data = req.pixel_in[PIXEL_BITS-1:0];
		if (accept) begin
			if (req.op == OP_WRITE) begin
				push = !loaded_q && (write_row_q < h_eff);
			end else if (!loaded_q) begin
				push       = 1'b1;
				cmd_c.kind = CMD_ERROR;
			end else begin
				push       = 1'b1;
				cmd_c.kind = CMD_READ;
				cmd_c.last = last;
				cmd_c.addr = AW'(sr) * AW'(MAX_SIDE) + AW'(sc);
			end
		end
		cmd = cmd_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_row_q <= '0;
			write_col_q <= '0;
			read_row_q  <= '0;
			read_col_q  <= '0;
			loaded_q    <= 1'b0;
		end else if (accept) begin
			if (req.op == OP_WRITE) begin
				if (!loaded_q) begin
					if (write_row_q >= h_eff) begin
						loaded_q <= 1'b1;
					end else if (col_inc >= w_eff) begin
						write_col_q <= '0;
						write_row_q <= row_inc;
						if (row_inc >= h_eff)
							loaded_q <= 1'b1;
					end else begin
						write_col_q <= CW'(col_inc);
					end
				end
			end else if (loaded_q) begin
				if (last) begin
					write_row_q <= '0;
					write_col_q <= '0;
					read_row_q  <= '0;
					read_col_q  <= '0;
					loaded_q    <= 1'b0;
				end else if (rc_inc >= ow) begin
					read_col_q <= '0;
					read_row_q <= CW'(rr_inc);
				end else begin
					read_row_q <= r;
					read_col_q <= CW'(rc_inc);
				end
			end
		end
	end

endmodule

FILE: rtl/ffr_queue.sv
// Short command queue between the front end and the frame store.
module ffr_queue import ffr_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slots_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == NW'(QUEUE_DEPTH));
	assign head    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + NW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - NW'(1);
		end
	end

endmodule

FILE: rtl/ffr_back.sv
// Back end: single-port frame store and the registered result stage.
module ffr_back import ffr_pkg::*; #(
	parameter int MAX_SIDE   = DEF_MAX_SIDE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int CMD_BITS   = 2 + 1 + $clog2(MAX_SIDE * MAX_SIDE) + PIXEL_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic [CMD_BITS-1:0] cmd,
	output logic                done,
	output result_t             result
);

	localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  last;
		logic [AW-1:0]         addr;
		logic [PIXEL_BITS-1:0] data;
	} cmd_t;

	cmd_t                  c;
	logic [PIXEL_BITS-1:0] store [DEPTH];
	logic [PIXEL_BITS-1:0] rd_data_s1;
	logic                  valid_s1, last_s1, err_s1;

	assign c = cmd_t'(cmd);

	always_ff @(posedge clk) begin
		if (cmd_valid && c.kind == CMD_WRITE)
			store[c.addr] <= c.data;
		if (cmd_valid && c.kind == CMD_READ)
			rd_data_s1 <= store[c.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			err_s1   <= 1'b0;
		end else begin
			valid_s1 <= cmd_valid && (c.kind == CMD_READ || c.kind == CMD_ERROR);
			last_s1  <= c.last;
			err_s1   <= (c.kind == CMD_ERROR);
		end
	end

	always_comb begin
		done              = valid_s1;
		result.pixel_out  = err_s1 ? 16'd0 : 16'(rd_data_s1);
		result.last_pixel = last_s1 && !err_s1;
		result.status     = err_s1;
	end

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the frame flip and rotate engine.
`timescale 1ns / 1ps

// Strategy: a stimulus process plans whole frames, with some deliberate
// misuse mixed in. Misuse here means early reads, writes while loaded, and
// size or mode changes in the middle of a frame. Planned requests go into a
// queue. A negedge driver feeds that queue to the engine with random gaps.
// A posedge monitor runs a behavioral model of the engine on every request
// the engine takes. It queues the expected pixel and compares it with each
// result the engine shows.
//
// The behavioral model keeps two copies of the engine state. The planning
// copy is advanced as requests are generated. It lets the stimulus see where
// the engine will be, so sizes only grow when a new frame starts. That
// guarantees no read ever lands on a frame store entry that was never
// written. The checking copy is advanced only on requests the engine
// actually takes, and on configuration writes it actually sees.
module tb;
	import ffr_pkg::*;

	localparam int MAX_SIDE      = DEF_MAX_SIDE;
	localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
	localparam int STORE_AW      = $clog2(STORE_DEPTH);
	localparam int RAND_ITEMS    = 1400;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int GAP_PERCENT   = 22;
	localparam int REPORT_MAX    = 10;

	// Indexes of the two copies of the model state.
	localparam int SHADOW_PLAN  = 0;
	localparam int SHADOW_CHECK = 1;

	// Result status codes.
	localparam logic ST_OK         = 1'b0;
	localparam logic ST_EARLY_READ = 1'b1;

	// A mode code past the defined ones; the engine treats it as pass-through.
	localparam logic [2:0] MODE_SPARE = 3'd6;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     start     = 1'b0;
	logic                     busy;
	req_t                     req       = '0;
	logic                     done;
	result_t                  result;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	frame_flip_rotate_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model state, one copy per index above.
	logic [15:0]  pix_mem [2][STORE_DEPTH];
	logic [8:0]   reg_w [2];
	logic [8:0]   reg_h [2];
	logic [2:0]   reg_mode [2];
	int unsigned  wr_row [2];
	int unsigned  wr_col [2];
	int unsigned  rd_row [2];
	int unsigned  rd_col [2];
	bit           loaded [2];

	req_t    pixel_reqs [$];   // requests planned but not yet taken
	result_t due_pixels [$];   // results the engine still owes, oldest first
	bit      req_taken;        // set by the monitor when the engine took the request
	bit      gaps_off = 1'b0;  // suppresses driver gaps for a stretch of the run
	int      mismatches = 0;
	int      stall_cycles = 0;

	// A programmed size of 0 behaves as 1, and one past MAX_SIDE behaves as MAX_SIDE.
	function automatic int unsigned side_len(input logic [8:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return 32'(v);
	endfunction

	function automatic void rearm_counters(input int k);
		wr_row[k] = 0;
		wr_col[k] = 0;
		rd_row[k] = 0;
		rd_col[k] = 0;
		loaded[k] = 1'b0;
	endfunction

	function automatic void apply_reg(input int k, input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		case (idx)
			REG_FRAME_WIDTH: begin
				reg_w[k] = val;
			end
			REG_FRAME_HEIGHT: begin
				reg_h[k] = val;
			end
			REG_ORIENT_MODE: begin
				reg_mode[k] = val[2:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Advances copy k of the model by one request. Returns 1 when the request
	// produces a result, which is then left in res.
	function automatic bit reorient_request(input int k, input req_t rq, output result_t res);
		int unsigned  w, h, ow, oh, r, c, sr, sc;
		orient_mode_t m;
		bit           last;
		res = '0;
		w = side_len(reg_w[k]);
		h = side_len(reg_h[k]);
		m = (reg_mode[k] > MODE_ROT270) ? MODE_PASS : orient_mode_t'(reg_mode[k]);

		if (rq.op == OP_WRITE) begin
			if (loaded[k])
				return 1'b0;
			// The frame may have shrunk under the write position, which
			// completes the frame without storing anything.
			if (wr_row[k] >= h) begin
				loaded[k] = 1'b1;
				return 1'b0;
			end
			pix_mem[k][STORE_AW'((wr_row[k] * MAX_SIDE + wr_col[k]) % STORE_DEPTH)] =
				rq.pixel_in;
			wr_col[k]++;
			if (wr_col[k] >= w) begin
				wr_col[k] = 0;
				wr_row[k]++;
				if (wr_row[k] >= h)
					loaded[k] = 1'b1;
			end
			return 1'b0;
		end

		if (!loaded[k]) begin
			res.status = ST_EARLY_READ;
			return 1'b1;
		end

		if (m == MODE_ROT90 || m == MODE_ROT270) begin
			ow = h;
			oh = w;
		end else begin
			ow = w;
			oh = h;
		end
		// The read position saturates if the output frame shrank mid-read.
		r = (rd_row[k] < oh) ? rd_row[k] : oh - 1;
		c = (rd_col[k] < ow) ? rd_col[k] : ow - 1;

		case (m)
			MODE_MIRROR_H: begin
				sr = r;
				sc = w - 1 - c;
			end
			MODE_MIRROR_V: begin
				sr = h - 1 - r;
				sc = c;
			end
			MODE_ROT90: begin
				sr = h - 1 - c;
				sc = r;
			end
			MODE_ROT180: begin
				sr = h - 1 - r;
				sc = w - 1 - c;
			end
			MODE_ROT270: begin
				sr = c;
				sc = w - 1 - r;
			end
			default: begin
				sr = r;
				sc = c;
			end
		endcase

		last = (r == oh - 1) && (c == ow - 1);
		res.pixel_out  = pix_mem[k][STORE_AW'((sr * MAX_SIDE + sc) % STORE_DEPTH)];
		res.last_pixel = last;
		res.status     = ST_OK;

		if (last) begin
			rearm_counters(k);
		end else begin
			c++;
			if (c >= ow) begin
				c = 0;
				r++;
			end
			rd_row[k] = r;
			rd_col[k] = c;
		end
		return 1'b1;
	endfunction

	// Driver. Requests change on the falling edge. A request the engine has
	// not taken yet stays on the port. Otherwise the next planned request
	// goes out, unless this cycle is picked as a gap.
	always @(negedge clk) begin
		if (req_taken)
			void'(pixel_reqs.pop_front());
		if (start && !req_taken) begin
			// Hold the current request until the engine takes it.
		end else if (pixel_reqs.size() != 0 &&
				(gaps_off || $urandom_range(99) >= GAP_PERCENT)) begin
			start <= 1'b1;
			req   <= pixel_reqs[0];
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor. Results are checked before a newly taken read queues its
	// expectation, so that a result arriving with nothing owed is not matched
	// against a request taken at the same edge.
	always @(posedge clk) begin : score
		result_t want;
		req_taken = 1'b0;
		if (arst_n) begin
			if (cfg_we)
				apply_reg(SHADOW_CHECK, cfg_idx, cfg_wdata);
			if (done) begin
				if (due_pixels.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("unexpected result: pixel %h last %b status %b",
							result.pixel_out, result.last_pixel, result.status);
					mismatches++;
				end else begin
					want = due_pixels.pop_front();
					if (result.pixel_out !== want.pixel_out ||
							result.last_pixel !== want.last_pixel ||
							result.status !== want.status) begin
						if (mismatches < REPORT_MAX)
							$display({"mismatch: expected pixel %h last %b status %b,",
								" got pixel %h last %b status %b"},
								want.pixel_out, want.last_pixel, want.status,
								result.pixel_out, result.last_pixel, result.status);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				req_taken = 1'b1;
				if (reorient_request(SHADOW_CHECK, req, want))
					due_pixels.push_back(want);
			end
		end
	end

	// Watchdog: ends the run if the engine neither takes a request nor shows
	// a result for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Plans one request against the planning copy and queues it for the driver.
	task automatic push_req(input logic op, input logic [15:0] pix, inout int counted);
		req_t    rq;
		result_t unused;
		rq.op       = op;
		rq.pixel_in = pix;
		if (op == OP_READ || !loaded[SHADOW_PLAN])
			counted++;
		void'(reorient_request(SHADOW_PLAN, rq, unused));
		pixel_reqs.push_back(rq);
	endtask

	// Waits until every planned request is taken and every result is in, then
	// keeps waiting so that writes still inside the pipeline can finish.
	task automatic settle();
		while (pixel_reqs.size() != 0 || due_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		apply_reg(SHADOW_PLAN, idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reconfigure(input logic [8:0] w, input logic [8:0] h,
			input logic [2:0] mode);
		settle();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_ORIENT_MODE, {6'd0, mode});
	endtask

	// One of the largest sides, sometimes programmed past MAX_SIDE.
	function automatic logic [8:0] big_side();
		case ($urandom_range(2))
			0: return 9'(MAX_SIDE);
			1: return 9'($urandom_range(511, MAX_SIDE + 1));
			default: return 9'($urandom_range(MAX_SIDE - 1, 200));
		endcase
	endfunction

	// A size that never exceeds the current one. Mid-frame, a size may only
	// shrink, so every entry read afterwards is one this frame wrote.
	function automatic logic [8:0] shrink_side(input logic [8:0] cur);
		return 9'($urandom_range(side_len(cur), 0));
	endfunction

	initial begin : stimulus
		int       n_items;
		int       frame;
		bit       big, wide, cut;
		logic [8:0] w, h;

		for (int k = 0; k < 2; k++) begin
			reg_w[k]    = MAX_SIDE;
			reg_h[k]    = MAX_SIDE;
			reg_mode[k] = MODE_PASS;
			rearm_counters(k);
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed part. First, a read before any frame is loaded must come
		// back as an error.
		n_items = 0;
		push_req(OP_READ, 16'hFFFF, n_items);

		// A 2x2 frame rotated by 90 degrees, carrying extreme pixel values. A
		// fifth write arrives after the frame is complete and must be
		// dropped. Half of the frame is then read.
		reconfigure(2, 2, MODE_ROT90);
		push_req(OP_WRITE, 16'h0000, n_items);
		push_req(OP_WRITE, 16'hFFFF, n_items);
		push_req(OP_WRITE, 16'h8001, n_items);
		push_req(OP_WRITE, 16'h7FFE, n_items);
		push_req(OP_WRITE, 16'h5555, n_items);
		push_req(OP_READ, 16'h0000, n_items);
		push_req(OP_READ, 16'h0000, n_items);

		// The frame shrinks to 2x1 after loading, and the mode becomes an
		// undefined code. The read position has run past the new output
		// frame, so it saturates. The second read is the last pixel.
		reconfigure(2, 1, MODE_SPARE);
		push_req(OP_READ, 16'h0000, n_items);
		push_req(OP_READ, 16'h0000, n_items);

		// A width of 0 acts as 1 and a height past the maximum acts as the
		// maximum. Three rows are written, then the height drops below the
		// write position. The next write completes the frame, and the
		// 270-degree readout has two pixels.
		reconfigure(0, 300, MODE_ROT270);
		push_req(OP_WRITE, 16'hA5A5, n_items);
		push_req(OP_WRITE, 16'h5A5A, n_items);
		push_req(OP_WRITE, 16'h1234, n_items);
		reconfigure(0, 2, MODE_ROT270);
		push_req(OP_WRITE, 16'hDEAD, n_items);
		push_req(OP_READ, 16'h0000, n_items);
		push_req(OP_READ, 16'h0000, n_items);

		// Random part. Each pass plans one full frame, which is loaded and
		// then read out, with stray requests mixed in. Now and then the frame
		// shrinks or the mode changes partway through. Most frames are tiny.
		// About one in twelve has one side large, near or at the maximum.
		n_items = 0;
		frame   = 0;
		while (n_items < RAND_ITEMS) begin
			gaps_off = (frame >= 6 && frame < 10);
			big  = ($urandom_range(11) == 0);
			wide = $urandom_range(1);
			if (big && wide)
				w = big_side();
			else if (big)
				w = 9'($urandom_range(2, 1));
			else
				w = 9'($urandom_range(6, 0));
			if (big && !wide)
				h = big_side();
			else if (big)
				h = 9'($urandom_range(2, 1));
			else
				h = 9'($urandom_range(6, 0));
			reconfigure(w, h, 3'($urandom_range(7)));

			cut = ($urandom_range(9) == 0);
			while (loaded[SHADOW_PLAN] == 1'b0) begin
				if ($urandom_range(19) == 0)
					push_req(OP_READ, 16'($urandom_range(16'hFFFF)), n_items);
				else
					push_req(OP_WRITE, 16'($urandom_range(16'hFFFF)), n_items);
				if (cut && !loaded[SHADOW_PLAN] && $urandom_range(3) == 0) begin
					cut = 1'b0;
					reconfigure(shrink_side(reg_w[SHADOW_PLAN]),
						shrink_side(reg_h[SHADOW_PLAN]), 3'($urandom_range(7)));
				end
			end

			if ($urandom_range(3) == 0)
				push_req(OP_WRITE, 16'($urandom_range(16'hFFFF)), n_items);

			cut = ($urandom_range(5) == 0);
			while (loaded[SHADOW_PLAN]) begin
				if ($urandom_range(24) == 0)
					push_req(OP_WRITE, 16'($urandom_range(16'hFFFF)), n_items);
				else
					push_req(OP_READ, 16'($urandom_range(16'hFFFF)), n_items);
				if (cut && loaded[SHADOW_PLAN] && $urandom_range(3) == 0) begin
					cut = 1'b0;
					reconfigure(shrink_side(reg_w[SHADOW_PLAN]),
						shrink_side(reg_h[SHADOW_PLAN]), 3'($urandom_range(7)));
				end
			end
			frame++;
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_pixels.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ffr_pkg.sv
rtl/ffr_front.sv
rtl/ffr_queue.sv
rtl/ffr_back.sv
rtl/frame_flip_rotate_engine.sv
bench/tb.sv
